[rtl/sorted_list_engine_defines.svh]
// Assertion macros shared by the sorted list engine RTL.
`ifndef SORTED_LIST_ENGINE_DEFINES_SVH
`define SORTED_LIST_ENGINE_DEFINES_SVH

// A condition in a cycle implies another condition in the same cycle.
`define SLE_ASSERT_SAME(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// A condition in a cycle implies another condition in the following cycle.
`define SLE_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

[rtl/sle_pkg.sv]
// Constants and request and status codes of the sorted list engine.
`timescale 1ns / 1ps
package sle_pkg;

  // Number of stored values and the widths that follow from it.
  localparam int CAPACITY = 32;
  localparam int AW       = $clog2(CAPACITY);
  localparam int CW       = $clog2(CAPACITY + 1);
  localparam int DW       = 32;

  // Request codes.
  typedef logic [1:0] req_t;
  localparam req_t REQ_INSERT = 2'd0;
  localparam req_t REQ_DELETE = 2'd1;
  localparam req_t REQ_READ   = 2'd2;

  // Result status codes.
  typedef logic [1:0] status_t;
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_FULL     = 2'd1;
  localparam status_t ST_EMPTY    = 2'd2;
  localparam status_t ST_NOTFOUND = 2'd3;

endpackage

[rtl/sle_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module sle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/sorted_list_engine.sv]
// Top level of the sorted list engine: request sequencer around the value RAM.
//
//   Channel | Direction | Handshake         | Payload
//   in_     | request   | in_valid/in_ready | in_req_type, in_value
//   out_    | result    | out_valid/out_ready | out_status, out_item, out_last
//
// Values sit in ascending order at RAM addresses 0 to occupancy-1.
// Insert walks down from the top, moving each greater-or-equal value up one
// place per cycle; when the list is empty or full it needs no walk. Delete
// walks up from address 0, moving later values down one place. Read out
// streams one value per cycle through the RAM read register and the output
// register, and halts while out_ready is low. After reset the list is empty;
// the RAM needs no clearing pass. A new request is taken once the previous
// result has entered the output register, even while it still waits there.
`timescale 1ns / 1ps
`include "sorted_list_engine_defines.svh"
module sorted_list_engine
  import sle_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_req_type,
  input  logic signed [DW-1:0] in_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_status,
  output logic signed [DW-1:0] out_item,
  output logic                 out_last
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS_LAST,
    S_DEL,
    S_READ,
    S_RESP
  } state_t;

  state_t               state_r, state_nxt;
  logic [CW-1:0]        occ_r, occ_nxt;
  logic [AW-1:0]        idx_r, idx_nxt;
  logic                 found_r, found_nxt;
  logic signed [DW-1:0] val_r, val_nxt;
  status_t              rstat_r, rstat_nxt;
  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r, out_status_nxt;
  logic signed [DW-1:0] out_item_r, out_item_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [DW-1:0]        ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [DW-1:0]        ram_rdata;

  logic                 out_free;
  logic [CW-1:0]        occ_m1;
  logic                 at_end;
  logic                 rd_less;
  logic                 rd_match;
  logic                 in_acc;
  logic                 out_phase;

  // Value store.
  sle_ram #(
    .WIDTH (DW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Helper terms for the walks.
  assign out_free  = !out_valid_r || out_ready;
  assign occ_m1    = occ_r - CW'(1);
  assign at_end    = ({1'b0, idx_r} == occ_m1);
  assign rd_less   = ($signed(ram_rdata) < val_r);
  assign rd_match  = (ram_rdata == val_r);
  assign in_acc    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_phase = (state_r == S_READ) || (state_r == S_RESP);

  // Sequencer next-state logic.
  always_comb begin
    state_nxt      = state_r;
    occ_nxt        = occ_r;
    idx_nxt        = idx_r;
    found_nxt      = found_r;
    val_nxt        = val_r;
    rstat_nxt      = rstat_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_item_nxt   = out_item_r;
    out_last_nxt   = out_last_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_r;
    ram_wdata      = val_r;
    ram_re         = 1'b0;
    ram_raddr      = idx_r;

    // The consumer takes the current result.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          val_nxt = in_value;
          case (in_req_type)
            REQ_INSERT: begin
              if (occ_r == CW'(CAPACITY)) begin
                rstat_nxt = ST_FULL;
                state_nxt = S_RESP;
              end else if (occ_r == '0) begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = in_value;
                occ_nxt   = occ_r + CW'(1);
                rstat_nxt = ST_OK;
                state_nxt = S_RESP;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = occ_m1[AW-1:0];
                idx_nxt   = occ_r[AW-1:0];
                state_nxt = S_INS;
              end
            end
            REQ_DELETE: begin
              if (occ_r == '0) begin
                rstat_nxt = ST_EMPTY;
                state_nxt = S_RESP;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                idx_nxt   = '0;
                found_nxt = 1'b0;
                state_nxt = S_DEL;
              end
            end
            REQ_READ: begin
              if (occ_r == '0) begin
                rstat_nxt = ST_EMPTY;
                state_nxt = S_RESP;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                idx_nxt   = '0;
                state_nxt = S_READ;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      // Read data is the value at idx_r-1; idx_r is the free slot above it.
      S_INS: begin
        ram_we = 1'b1;
        if (!rd_less) begin
          ram_waddr = idx_r;
          ram_wdata = ram_rdata;
          idx_nxt   = idx_r - AW'(1);
          if (idx_r == AW'(1)) begin
            state_nxt = S_INS_LAST;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = idx_r - AW'(2);
          end
        end else begin
          ram_waddr = idx_r;
          ram_wdata = val_r;
          occ_nxt   = occ_r + CW'(1);
          rstat_nxt = ST_OK;
          state_nxt = S_RESP;
        end
      end

      // Every stored value moved up; the new value goes to the bottom.
      S_INS_LAST: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = val_r;
        occ_nxt   = occ_r + CW'(1);
        rstat_nxt = ST_OK;
        state_nxt = S_RESP;
      end

      // Read data is the value at idx_r; values after the match move down.
      S_DEL: begin
        if (found_r) begin
          ram_we    = 1'b1;
          ram_waddr = idx_r - AW'(1);
          ram_wdata = ram_rdata;
        end else if (rd_match) begin
          found_nxt = 1'b1;
        end
        if (at_end) begin
          if (found_r || rd_match) begin
            occ_nxt   = occ_m1;
            rstat_nxt = ST_OK;
          end else begin
            rstat_nxt = ST_NOTFOUND;
          end
          state_nxt = S_RESP;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx_r + AW'(1);
          idx_nxt   = idx_r + AW'(1);
        end
      end

      // Read data holds the value at idx_r until the output register takes it.
      S_READ: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_item_nxt   = $signed(ram_rdata);
          out_last_nxt   = at_end;
          if (at_end) begin
            state_nxt = S_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = idx_r + AW'(1);
            idx_nxt   = idx_r + AW'(1);
          end
        end
      end

      // Single result of an insert, a delete or an empty read out.
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = rstat_r;
          out_item_nxt   = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r        <= idx_nxt;
    found_r      <= found_nxt;
    val_r        <= val_nxt;
    rstat_r      <= rstat_nxt;
    out_status_r <= out_status_nxt;
    out_item_r   <= out_item_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_item   = out_item_r;
  assign out_last   = out_last_r;

  // Checks on the sequencer.
  `SLE_ASSERT_SAME(a_occ_bound, 1'b1, occ_r <= CW'(CAPACITY), "occupancy above capacity")
  `SLE_ASSERT_SAME(a_read_no_write, state_r == S_READ, !ram_we, "RAM written during read out")
  `SLE_ASSERT_SAME(a_err_last, out_valid && (out_status != ST_OK), out_last, "error not last")
  `SLE_ASSERT_NEXT(a_occ_idle, out_phase, $stable(occ_r), "occupancy changed outside a walk")

endmodule
